[sv/spritz_pkg.sv]
package spritz_pkg;

    localparam int unsigned N_ENTRIES = 256;
    localparam int unsigned IDX_W     = 8;
    localparam logic [7:0]  HALF      = 8'h80;
    localparam logic [7:0]  BYTE_MAX  = 8'hff;
    localparam logic [7:0]  W_INC     = 8'd2;
    localparam logic [7:0]  W_RESET   = 8'd1;

    typedef enum logic [1:0] {
        CMD_RESET = 2'd0,
        CMD_ABSORB = 2'd1,
        CMD_CRYPT = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_NIB_CHK,
        ST_NIB_RDA,
        ST_NIB_RDB,
        ST_NIB_WR,
        ST_UP_RDI,
        ST_UP_RDJ1,
        ST_UP_RDJ2,
        ST_UP_WR,
        ST_CR_RDA,
        ST_CR_RDB,
        ST_CR_WR,
        ST_Z_RD1,
        ST_Z_RD2,
        ST_Z_RD3,
        ST_Z_DONE,
        ST_OUT
    } t_state;

    // memory request from the controller to the table
    typedef struct packed {
        logic [7:0] raddr;
        logic       we;
        logic [7:0] waddr;
        logic [7:0] wdata;
        logic       we2;
        logic [7:0] waddr2;
        logic [7:0] wdata2;
    } t_mem_req;

endpackage

[sv/spritz_stream_cipher.sv]
// Spritz stream cipher over a 256-byte permutation held in one synchronous
// memory. Send transactions with tdata = {6'b0, data_byte, command}: command 0
// re-initializes (a clearing pass rewrites the table to identity), 1 absorbs
// a key byte, 2 crypts one byte and returns data XOR keystream. The first
// crypt after absorbing key runs a shuffle: three whips of 512 update steps
// plus two crushes of 128 compare-swaps; a shuffle also runs when 128 nibbles
// have been absorbed. Every step is bounded by the single read port of the
// table. One result is held in the output register; a further crypt waits at
// its last cycle until that result is taken. After the reset pin the clearing
// pass runs before the first transaction is accepted.
module spritz_stream_cipher
    import spritz_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [1:0] command, [9:2] data_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [7:0] out_byte
);

    t_state     r_state, n_state;
    t_mem_req   mreq;
    logic [7:0] rdata;

    logic [7:0] r_i, n_i, r_j, n_j, r_k, n_k, r_z, n_z, r_w, n_w, r_a, n_a;
    logic [7:0] r_t1, n_t1, r_t2, n_t2, r_data, n_data, r_cnt, n_cnt;
    logic [9:0] r_step, n_step;   // update steps done in whip
    logic [1:0] r_phase, n_phase; // shuffle phase: whips done
    logic       r_shuf, n_shuf;   // in shuffle
    logic       r_hi, n_hi;       // second nibble pending
    logic       r_crypt, n_crypt; // update belongs to drip
    logic       r_ov, n_ov;
    logic [7:0] r_ob, n_ob;

    spritz_ram u_ram (.i_clk(i_clk), .i_req(mreq), .o_rdata(rdata));

    // state and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cnt   <= '0;
            r_i <= '0; r_j <= '0; r_k <= '0; r_z <= '0; r_w <= W_RESET; r_a <= '0;
            r_ov <= 1'b0; r_shuf <= 1'b0; r_hi <= 1'b0; r_crypt <= 1'b0;
            r_phase <= '0; r_step <= '0;
        end else begin
            r_state <= n_state; r_cnt <= n_cnt;
            r_i <= n_i; r_j <= n_j; r_k <= n_k; r_z <= n_z; r_w <= n_w; r_a <= n_a;
            r_ov <= n_ov; r_shuf <= n_shuf; r_hi <= n_hi; r_crypt <= n_crypt;
            r_phase <= n_phase; r_step <= n_step;
        end
        r_t1 <= n_t1; r_t2 <= n_t2; r_data <= n_data; r_ob <= n_ob;
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_ob;

    // controller: next state, memory requests
    always_comb begin
        n_state = r_state; n_cnt = r_cnt;
        n_i = r_i; n_j = r_j; n_k = r_k; n_z = r_z; n_w = r_w; n_a = r_a;
        n_t1 = r_t1; n_t2 = r_t2; n_data = r_data; n_ob = r_ob;
        n_ov = r_ov; n_shuf = r_shuf; n_hi = r_hi; n_crypt = r_crypt;
        n_phase = r_phase; n_step = r_step;
        mreq = '0;
        if (r_ov && m_axis_tready) begin
            n_ov = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    n_data = s_axis_tdata[9:2];
                    unique case (t_cmd'(s_axis_tdata[1:0]))
                        CMD_RESET: begin
                            n_cnt = '0; n_state = ST_CLEAR;
                            n_i = '0; n_j = '0; n_k = '0; n_z = '0; n_w = W_RESET;
                            n_a = '0;
                        end
                        CMD_ABSORB: begin
                            n_hi = 1'b1; n_state = ST_NIB_CHK;
                        end
                        CMD_CRYPT: begin
                            n_crypt = 1'b1;
                            if (r_a != 8'd0) begin
                                n_shuf = 1'b1; n_phase = '0; n_step = '0;
                                n_state = ST_UP_RDI;
                            end else begin
                                n_state = ST_UP_RDI;
                            end
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR: begin
                // rewrite the table to identity, one entry a cycle
                mreq.we = 1'b1; mreq.waddr = r_cnt; mreq.wdata = r_cnt;
                n_cnt = r_cnt + 8'd1;
                if (r_cnt == BYTE_MAX) n_state = ST_IDLE;
            end
            ST_NIB_CHK: begin
                if (r_a == HALF) begin
                    n_shuf = 1'b1; n_phase = '0; n_step = '0; n_crypt = 1'b0;
                    n_state = ST_UP_RDI;
                end else begin
                    n_state = ST_NIB_RDA;
                end
            end
            ST_NIB_RDA: begin
                mreq.raddr = r_a;
                n_t2 = HALF | {4'd0, r_hi ? r_data[3:0] : r_data[7:4]};
                n_state = ST_NIB_RDB;
            end
            ST_NIB_RDB: begin
                mreq.raddr = r_t2;
                n_t1 = rdata;
                n_state = ST_NIB_WR;
            end
            ST_NIB_WR: begin
                // swap S[a] and S[128+nibble]; second write wins on same entry
                mreq.we = 1'b1; mreq.waddr = r_a; mreq.wdata = rdata;
                mreq.we2 = 1'b1; mreq.waddr2 = r_t2; mreq.wdata2 = r_t1;
                n_a = r_a + 8'd1;
                if (r_hi) begin
                    n_hi = 1'b0; n_state = ST_NIB_CHK;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_UP_RDI: begin
                // update step: read S[i+w]
                n_i = r_i + r_w;
                mreq.raddr = r_i + r_w;
                n_state = ST_UP_RDJ1;
            end
            ST_UP_RDJ1: begin
                n_t1 = rdata; // S[i]
                mreq.raddr = r_j + rdata;
                n_state = ST_UP_RDJ2;
            end
            ST_UP_RDJ2: begin
                n_j = r_k + rdata;
                mreq.raddr = r_k + rdata;
                n_state = ST_UP_WR;
            end
            ST_UP_WR: begin
                n_k = r_i + r_k + rdata;
                mreq.we = 1'b1; mreq.waddr = r_i; mreq.wdata = rdata;
                mreq.we2 = 1'b1; mreq.waddr2 = r_j; mreq.wdata2 = r_t1;
                if (r_shuf) begin
                    n_step = r_step + 10'd1;
                    if (r_step == 10'd511) begin
                        n_w = r_w + W_INC;
                        n_step = '0;
                        if (r_phase == 2'd2) begin
                            n_shuf = 1'b0; n_a = '0;
                            n_state = r_crypt ? ST_UP_RDI : ST_NIB_RDA;
                        end else begin
                            n_phase = r_phase + 2'd1;
                            n_cnt = '0;
                            n_state = ST_CR_RDA;
                        end
                    end else begin
                        n_state = ST_UP_RDI;
                    end
                end else begin
                    n_state = ST_Z_RD1;
                end
            end
            ST_CR_RDA: begin
                mreq.raddr = r_cnt;
                n_state = ST_CR_RDB;
            end
            ST_CR_RDB: begin
                mreq.raddr = BYTE_MAX - r_cnt;
                n_t1 = rdata;
                n_state = ST_CR_WR;
            end
            ST_CR_WR: begin
                if (r_t1 > rdata) begin
                    mreq.we = 1'b1; mreq.waddr = r_cnt; mreq.wdata = rdata;
                    mreq.we2 = 1'b1; mreq.waddr2 = BYTE_MAX - r_cnt;
                    mreq.wdata2 = r_t1;
                end
                n_cnt = r_cnt + 8'd1;
                n_state = (r_cnt == HALF - 8'd1) ? ST_UP_RDI : ST_CR_RDA;
            end
            ST_Z_RD1: begin
                mreq.raddr = r_z + r_k;
                n_state = ST_Z_RD2;
            end
            ST_Z_RD2: begin
                mreq.raddr = r_i + rdata;
                n_state = ST_Z_RD3;
            end
            ST_Z_RD3: begin
                mreq.raddr = r_j + rdata;
                n_state = ST_Z_DONE;
            end
            ST_Z_DONE: begin
                n_z = rdata;
                n_crypt = 1'b0;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                // hold until the output register is free or being drained
                if (!r_ov || m_axis_tready) begin
                    n_ob = r_data ^ r_z;
                    n_ov = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !s_axis_tready) else $error("accept while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("output changed under stall");
    a_nib_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_NIB_WR) |-> (r_a < HALF)) else $error("nibble count overrun");
`endif

endmodule

[sv/spritz_ram.sv]
module spritz_ram
    import spritz_pkg::*;
(
    input  logic       i_clk,
    input  t_mem_req   i_req,
    output logic [7:0] o_rdata
);

    logic [7:0] r_mem [N_ENTRIES];
    logic [7:0] r_rdata;

    // write both swap entries, read one (registered)
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.we2) begin
            r_mem[i_req.waddr2] <= i_req.wdata2;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule
